@@ hw/rtl/lbfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfe_pkg
// Shared types and constants of the breathe/fade envelope block.
// ----------------------------------------------------------------------------
package lbfe_pkg;

  // One input item: step or clear, signal-present flag, millisecond time
  typedef struct packed {
    logic        action;
    logic        present;
    logic [31:0] now_time;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] level;
    logic       show;
  } out_item_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START1,
    ST_DIV1,
    ST_MUL,
    ST_DIV2,
    ST_DONE
  } state_t;

  // Action codes
  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_FLOOR    = 3'd0;
  localparam logic [2:0] CFG_CEILING  = 3'd1;
  localparam logic [2:0] CFG_PERIOD   = 3'd2;
  localparam logic [2:0] CFG_FADE     = 3'd3;
  localparam logic [2:0] CFG_REFRESH  = 3'd4;

  // Register reset values
  localparam logic [7:0]  FLOOR_RST   = 8'd20;
  localparam logic [7:0]  CEILING_RST = 8'd128;
  localparam logic [15:0] PERIOD_RST  = 16'd100;
  localparam logic [15:0] FADE_RST    = 16'd400;
  localparam logic [15:0] REFRESH_RST = 16'd10;

endpackage

@@ hw/rtl/led_breathe_fade_envelope_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_breathe_fade_envelope_top
// Green breathe/fade envelope with throttled, change-detected strip refresh.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per tick (step with time and present flag) or clear.
//   out_* : exactly one result transfer per input: level and show flag.
//   cfg_* : register writes (floor, ceiling, period, fade time, refresh
//           interval); cfg_ready is always high, write only while idle.
// Operation:
//   A step makes two passes through the DW-bit bit-serial divider, where
//   DW = max(TIME_BITS, 32) (time mod period or elapsed / fade time, then
//   the scaled triangle or fade remainder), one bit per cycle. A clear
//   skips the divider and goes straight to the result.
//   The block works on one item at a time; in_ready is high only between
//   items, so no new item is taken before the last one is finished.
// Reset:
//   Synchronous, active low. Registers return to their defaults, the
//   envelope is dark, the refresh deadline is zero and the next step only
//   records its time.
// Stall:
//   A finished result waits in the output register while out_ready is low;
//   the next input is still taken and worked on, and its result waits
//   until the previous one has been transferred.
// ----------------------------------------------------------------------------
module led_breathe_fade_envelope_top #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lbfe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lbfe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int DW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int NW = (TIME_BITS < 32) ? TIME_BITS : 32;

  // Configuration registers
  logic [7:0]  floor_r;
  logic [7:0]  ceil_r;
  logic [15:0] period_r;
  logic [15:0] fade_r;
  logic [15:0] refresh_r;

  // Envelope state
  lbfe_pkg::state_t     state_r, state_nxt;
  logic                 started_r;
  logic [7:0]           env_r;
  logic [TIME_BITS-1:0] prev_r;
  logic [7:0]           shown_r;
  logic [TIME_BITS-1:0] next_ref_r;

  // Captured item
  logic                 act_r;
  logic                 pres_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] dt_r;
  logic [7:0]           cur_r;
  logic [15:0]          qc_r;
  logic                 qbig_r;

  // Output register
  logic                 out_valid_r;
  lbfe_pkg::out_item_t  out_data_r;

  // Divider
  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [15:0]          div_divisor;
  lbfe_pkg::div_stat_t  div_stat;
  logic [DW-1:0]        div_quot;
  logic [15:0]          div_rem;

  logic                 in_fire;
  logic                 fin_go;
  logic [TIME_BITS-1:0] now_in;
  logic [15:0]          period_eff;
  logic [15:0]          fade_eff;
  logic [15:0]          half;
  logic [15:0]          tri_val;
  logic [7:0]           span;
  logic                 rising;
  logic [23:0]          prod2;
  logic [7:0]           lvl_nxt;
  logic [8:0]           sum9;
  logic                 v_hi;
  logic [16:0]          dec17;
  logic [TIME_BITS-1:0] rdiff;
  logic                 due;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign now_in    = TIME_BITS'(in_data.now_time[NW-1:0]);

  // Clamp degenerate period and fade time
  assign period_eff = (period_r < 16'd2) ? 16'd2 : period_r;
  assign fade_eff   = (fade_r == '0) ? 16'd1 : fade_r;
  assign half       = {1'b0, period_eff[15:1]};

  // Triangle from the phase left by pass one
  assign tri_val = (div_rem < half) ? div_rem : (period_eff - div_rem);
  assign rising  = (ceil_r >= floor_r);
  assign span    = rising ? (ceil_r - floor_r) : (floor_r - ceil_r);
  assign prod2   = pres_r ? (24'(span) * 24'(tri_val)) : (24'(div_rem) * 24'(ceil_r));

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r   <= lbfe_pkg::FLOOR_RST;
      ceil_r    <= lbfe_pkg::CEILING_RST;
      period_r  <= lbfe_pkg::PERIOD_RST;
      fade_r    <= lbfe_pkg::FADE_RST;
      refresh_r <= lbfe_pkg::REFRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbfe_pkg::CFG_FLOOR:   floor_r   <= cfg_data[7:0];
        lbfe_pkg::CFG_CEILING: ceil_r    <= cfg_data[7:0];
        lbfe_pkg::CFG_PERIOD:  period_r  <= cfg_data;
        lbfe_pkg::CFG_FADE:    fade_r    <= cfg_data;
        lbfe_pkg::CFG_REFRESH: refresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbfe_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_data.action == lbfe_pkg::ACT_CLEAR) ?
                      lbfe_pkg::ST_DONE : lbfe_pkg::ST_START1;
        end
      end
      lbfe_pkg::ST_START1: state_nxt = lbfe_pkg::ST_DIV1;
      lbfe_pkg::ST_DIV1: begin
        if (div_stat.done) state_nxt = lbfe_pkg::ST_MUL;
      end
      lbfe_pkg::ST_MUL:    state_nxt = lbfe_pkg::ST_DIV2;
      lbfe_pkg::ST_DIV2: begin
        if (div_stat.done) state_nxt = lbfe_pkg::ST_DONE;
      end
      lbfe_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = lbfe_pkg::ST_IDLE;
      end
      default: state_nxt = lbfe_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    fin_go       = 1'b0;
    div_dividend = pres_r ? DW'(now_r) : DW'(dt_r);
    div_divisor  = pres_r ? period_eff : fade_eff;
    case (state_r)
      lbfe_pkg::ST_IDLE:   in_ready  = 1'b1;
      lbfe_pkg::ST_START1: div_start = 1'b1;
      lbfe_pkg::ST_MUL: begin
        // Second pass: scaled triangle over half, or remainder*ceiling over fade
        div_start    = 1'b1;
        div_dividend = DW'(prod2);
        div_divisor  = pres_r ? half : fade_eff;
      end
      lbfe_pkg::ST_DONE:   fin_go = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lbfe_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  lbfe_div #(
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .stat    (div_stat),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  // ---------------------------------------------------------------------
  // Capture the item; a step records its time at once
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_data.action;
      pres_r <= in_data.present;
      now_r  <= now_in;
      dt_r   <= started_r ? (now_in - prev_r) : '0;
      cur_r  <= started_r ? env_r : '0;
    end
    if (in_fire && in_data.action == lbfe_pkg::ACT_STEP) begin
      prev_r <= now_in;
    end
    // Keep the whole quotient's size and q*ceiling before pass two
    if (state_r == lbfe_pkg::ST_MUL) begin
      qc_r   <= 16'(div_quot[7:0]) * 16'(ceil_r);
      qbig_r <= |div_quot[DW-1:8];
    end
  end

  // ---------------------------------------------------------------------
  // New level from the second quotient
  // ---------------------------------------------------------------------
  assign v_hi  = |div_quot[DW-1:8];
  assign sum9  = {1'b0, floor_r} + {1'b0, div_quot[7:0]};
  assign dec17 = 17'(qc_r) + 17'(div_quot[7:0]);

  always_comb begin
    if (pres_r) begin
      if (rising) begin
        lvl_nxt = (v_hi || sum9[8]) ? 8'hFF : sum9[7:0];
      end else begin
        lvl_nxt = (v_hi || div_quot[7:0] >= floor_r) ? 8'd0 : (floor_r - div_quot[7:0]);
      end
    end else if (cur_r == '0 || ceil_r == '0) begin
      lvl_nxt = cur_r;
    end else if (qbig_r || dec17 >= 17'(cur_r)) begin
      lvl_nxt = 8'd0;
    end else begin
      lvl_nxt = cur_r - dec17[7:0];
    end
  end

  // Refresh is due when now has reached the deadline, wrapping
  assign rdiff = now_r - next_ref_r;
  assign due   = !rdiff[TIME_BITS-1];

  // ---------------------------------------------------------------------
  // Commit state and load the output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      env_r       <= '0;
      shown_r     <= '0;
      next_ref_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire && in_data.action == lbfe_pkg::ACT_STEP) begin
        started_r <= 1'b1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (act_r == lbfe_pkg::ACT_CLEAR) begin
          started_r  <= 1'b0;
          env_r      <= '0;
          shown_r    <= '0;
          next_ref_r <= '0;
        end else begin
          env_r <= lvl_nxt;
          if (due) begin
            next_ref_r <= now_r + TIME_BITS'(refresh_r);
            shown_r    <= lvl_nxt;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (act_r == lbfe_pkg::ACT_CLEAR) begin
        out_data_r.level <= '0;
        out_data_r.show  <= 1'b1;
      end else begin
        out_data_r.level <= lvl_nxt;
        out_data_r.show  <= due && (lvl_nxt != shown_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished item not loaded into output register");

  a_shown_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !fin_go |=> $stable(shown_r))
    else $error("shown level changed outside commit");

  a_fade_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && act_r == lbfe_pkg::ACT_STEP && !pres_r) |-> (lvl_nxt <= cur_r))
    else $error("fade raised the envelope");

  a_show_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && act_r == lbfe_pkg::ACT_STEP) |=> (out_data_r.show == ($past(shown_r) != shown_r)))
    else $error("show flag disagrees with shown level update");

endmodule

@@ hw/rtl/lbfe_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfe_div
// Bit-serial restoring divider: DW-bit dividend by nonzero 16-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbfe_div #(
  parameter int DW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [15:0]         divisor,
  output lbfe_pkg::div_stat_t stat,
  output logic [DW-1:0]       quot,
  output logic [15:0]         rem
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [DW-1:0] dvd_r;
  logic [15:0]   rem_r;
  logic [15:0]   dsr_r;

  logic [16:0] shifted;
  logic [16:0] diff;
  logic        ge;

  assign shifted = {rem_r, dvd_r[DW-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign ge      = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(DW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Shift one dividend bit into the partial remainder, one quotient bit out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= ge ? diff[15:0] : shifted[15:0];
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quot      = dvd_r;
  assign rem       = rem_r;

endmodule

@@ bench/led_breathe_fade_envelope_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_breathe_fade_envelope_top_tb
// Self-checking bench for the breathe/fade envelope: a queue-fed driver pushes
// tick and clear transfers, a shadow envelope calculator predicts level and
// show for each accepted tick, and a monitor checks every result transfer in
// order across several register settings with random idling and back-pressure.
// ----------------------------------------------------------------------------
module led_breathe_fade_envelope_top_tb;

  localparam int          HALF_PERIOD      = 6;
  localparam int          RESET_CYCLES     = 8;
  localparam int          CYCLE_LIMIT      = 1_000_000;
  localparam int          HOLD_CYCLES      = 400;
  localparam int          SETTLE_CYCLES    = 80;
  localparam int          PHASE_COUNT      = 9;
  localparam int          PHASE_TICKS      = 125;
  localparam logic [2:0]  CFG_FIRST_UNUSED = lbfe_pkg::CFG_REFRESH + 3'd1;
  localparam logic [2:0]  CFG_LAST_CODE    = 3'h7;

  // Clock, reset and block ports; every input known from time zero
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  lbfe_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lbfe_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data  = '0;

  // Stimulus side
  lbfe_pkg::in_item_t  tick_q[$];
  int          send_idle_pct = 26;
  int          recv_idle_pct = 49;
  bit          send_pause    = 1'b0;
  int          hold_req      = 0;
  int          hold_ack      = 0;
  int          hold_left     = 0;
  logic [31:0] gen_time      = '0;
  bit          gen_present   = 1'b1;

  // Shadow registers and envelope state
  logic [7:0]  set_floor;
  logic [7:0]  set_ceiling;
  logic [15:0] set_period;
  logic [15:0] set_fade;
  logic [15:0] set_refresh;
  bit          env_started;
  logic [7:0]  env_level;
  logic [31:0] env_prev_time;
  logic [7:0]  env_shown;
  logic [31:0] env_next_refresh;

  lbfe_pkg::out_item_t expected_levels[$];
  int          result_count = 0;
  int          fail_count   = 0;
  int          cycle_count  = 0;

  led_breathe_fade_envelope_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("led_breathe_fade_envelope_top: mismatch");
      $finish;
    end
  end

  // Print one line per failed check and count it
  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  // Advance the shadow envelope by one accepted tick and return the result
  // the block should produce for it.
  function automatic lbfe_pkg::out_item_t compute_envelope(input lbfe_pkg::in_item_t it);
    logic [63:0] period, half, phase, tri_pos, v, fdiv, q, r, dec;
    logic [31:0] dt, lag;
    lbfe_pkg::out_item_t res;
    res.level = 8'd0;
    res.show  = 1'b1;
    // Clear: drop all state, strip driven dark
    if (it.action == lbfe_pkg::ACT_CLEAR) begin
      env_started      = 1'b0;
      env_level        = 8'd0;
      env_shown        = 8'd0;
      env_next_refresh = 32'd0;
      return res;
    end
    // First tick after reset or clear only records its time
    if (!env_started) begin
      env_level     = 8'd0;
      env_prev_time = it.now_time;
      env_started   = 1'b1;
    end
    dt            = it.now_time - env_prev_time;
    env_prev_time = it.now_time;
    if (it.present) begin
      // Triangle from floor to ceiling; periods below two act as two
      period  = (set_period < 16'd2) ? 64'd2 : 64'(set_period);
      half    = period / 2;
      phase   = 64'(it.now_time) % period;
      tri_pos = (phase < half) ? phase : period - phase;
      if (set_ceiling >= set_floor) begin
        v = 64'(set_floor) + 64'(set_ceiling - set_floor) * tri_pos / half;
        env_level = (v > 64'd255) ? 8'hFF : v[7:0];
      end else begin
        // Ceiling under floor: descend from the floor, clamp at zero
        v = 64'(set_floor - set_ceiling) * tri_pos / half;
        env_level = (v >= 64'(set_floor)) ? 8'd0 : set_floor - v[7:0];
      end
    end else if (env_level != 8'd0 && set_ceiling != 8'd0) begin
      // Fade by dt*ceiling/fade_time at full width; zero fade time acts as one
      fdiv = (set_fade == 16'd0) ? 64'd1 : 64'(set_fade);
      q    = 64'(dt) / fdiv;
      r    = 64'(dt) % fdiv;
      if (q >= 64'd256) begin
        env_level = 8'd0;
      end else begin
        dec = q * set_ceiling + r * set_ceiling / fdiv;
        env_level = (dec >= 64'(env_level)) ? 8'd0 : env_level - dec[7:0];
      end
    end
    res.level = env_level;
    res.show  = 1'b0;
    // Throttle: refresh due while now has not fallen behind the deadline
    lag = it.now_time - env_next_refresh;
    if (!lag[31]) begin
      env_next_refresh = it.now_time + 32'(set_refresh);
      if (env_level != env_shown) begin
        env_shown = env_level;
        res.show  = 1'b1;
      end
    end
    return res;
  endfunction

  // Monitor: track register writes, predict on each input transfer and check
  // each result transfer against the oldest prediction.
  always @(posedge clk) begin
    lbfe_pkg::out_item_t want;
    if (!rst_n) begin
      set_floor        = lbfe_pkg::FLOOR_RST;
      set_ceiling      = lbfe_pkg::CEILING_RST;
      set_period       = lbfe_pkg::PERIOD_RST;
      set_fade         = lbfe_pkg::FADE_RST;
      set_refresh      = lbfe_pkg::REFRESH_RST;
      env_started      = 1'b0;
      env_level        = 8'd0;
      env_prev_time    = 32'd0;
      env_shown        = 8'd0;
      env_next_refresh = 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lbfe_pkg::CFG_FLOOR:   set_floor   = cfg_data[7:0];
          lbfe_pkg::CFG_CEILING: set_ceiling = cfg_data[7:0];
          lbfe_pkg::CFG_PERIOD:  set_period  = cfg_data;
          lbfe_pkg::CFG_FADE:    set_fade    = cfg_data;
          lbfe_pkg::CFG_REFRESH: set_refresh = cfg_data;
          default: ;  // unused index: write dropped
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending (level %0d show %0d)",
                                    result_count, out_data.level, out_data.show));
        end else begin
          want = expected_levels.pop_front();
          if (out_data.level !== want.level)
            report_mismatch($sformatf("result %0d level %0d, expected %0d",
                                      result_count, out_data.level, want.level));
          if (out_data.show !== want.show)
            report_mismatch($sformatf("result %0d show %0d, expected %0d",
                                      result_count, out_data.show, want.show));
        end
        result_count++;
      end
      if (in_valid && in_ready)
        expected_levels.push_back(compute_envelope(in_data));
    end
  end

  // Driver: hold valid and payload until the transfer, then advance to the
  // next queued tick unless idling or paused.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() != 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One register write; drop valid again after the transfer
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] fl, input logic [15:0] ce,
                                input logic [15:0] pe, input logic [15:0] fa,
                                input logic [15:0] re);
    cfg_write(lbfe_pkg::CFG_FLOOR, fl);
    cfg_write(lbfe_pkg::CFG_CEILING, ce);
    cfg_write(lbfe_pkg::CFG_PERIOD, pe);
    cfg_write(lbfe_pkg::CFG_FADE, fa);
    cfg_write(lbfe_pkg::CFG_REFRESH, re);
  endtask

  // Wait until every queued tick is sent and every result has come back,
  // then let the pipeline settle.
  task automatic drain_block();
    while (tick_q.size() != 0 || in_valid || expected_levels.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Random tick: mostly time-ordered runs with present streaks, some clears
  // and some off-sequence timestamps.
  task automatic gen_tick(output lbfe_pkg::in_item_t it);
    int unsigned pick;
    int unsigned span;
    pick       = $urandom_range(99);
    it.action  = lbfe_pkg::ACT_STEP;
    it.present = 1'($urandom_range(1));
    it.now_time = $urandom;
    if (pick < 4) begin
      it.action = lbfe_pkg::ACT_CLEAR;
    end else if (pick >= 12) begin
      // Move close to the time wrap now and then
      if (pick < 14)
        gen_time = 32'hFFFF_FF00 + 32'($urandom_range(255));
      span = $urandom_range(99);
      span = (span < 35) ? 15 : (span < 70) ? 300 : (span < 90) ? 5000 : 200000;
      gen_time = gen_time + 32'($urandom_range(span));
      if ($urandom_range(99) < 15)
        gen_present = ~gen_present;
      it.present  = gen_present;
      it.now_time = gen_time;
    end
  endtask

  initial begin
    lbfe_pkg::in_item_t it;
    int       half_mark;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed ticks at reset settings: first tick, triangle peak and ends,
    // fade to zero, hold at zero, long gap, time wrap, throttle not due,
    // unchanged level, clears back to back.
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'd0});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'd5});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'd50});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'd99});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b0, 32'd199});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b0, 32'd300});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'd375});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b0, 32'd475});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b0, 32'd476});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b0, 32'd120476});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'hFFFF_FFFF});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b0, 32'h0000_0031});
    tick_q.push_back({lbfe_pkg::ACT_CLEAR, 1'b1, 32'h8000_0000});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b0, 32'h8000_0000});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'h8000_0019});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'hFFFF_FFF0});
    tick_q.push_back({lbfe_pkg::ACT_CLEAR, 1'b0, 32'h0000_0000});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'd0});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'd0});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b0, 32'h7FFF_FFFF});
    tick_q.push_back({lbfe_pkg::ACT_CLEAR, 1'b1, 32'hFFFF_FFFF});
    tick_q.push_back({lbfe_pkg::ACT_CLEAR, 1'b0, 32'h1234_5678});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'h5555_5555});
    tick_q.push_back({lbfe_pkg::ACT_STEP,  1'b1, 32'hAAAA_AAAA});
    drain_block();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      // Idle split: sender light / receiver heavy, then swapped, then none
      if (ph == 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 26;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: apply_settings(16'd0, 16'd255, 16'd2, 16'd1, 16'd0);
        1: apply_settings(16'd255, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_settings(16'd200, 16'd50, 16'd7, 16'd0, 16'd3);
        3: apply_settings(16'd10, 16'd0, 16'd1, 16'd300, 16'd20);
        5: apply_settings(16'd128, 16'd128, 16'd0, 16'hFFFF, 16'd1);
        6: apply_settings(16'd100, 16'd255, 16'd3, 16'd2, 16'd5);
        default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(2, 400)),
                                16'($urandom), 16'($urandom_range(0, 60)));
      endcase
      // A write to an unused index must leave every register alone
      cfg_write(3'($urandom_range(CFG_LAST_CODE, CFG_FIRST_UNUSED)), 16'($urandom));
      @(negedge clk);
      gen_time = $urandom;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        gen_tick(it);
        tick_q.push_back(it);
      end
      // Long receiver hold-off while ticks keep coming: fill the block
      if (ph == 0)
        hold_req++;
      // Sender pause halfway until every pending result is back
      if (ph == 4) begin
        half_mark = PHASE_TICKS / 2;
        while (tick_q.size() > half_mark) @(negedge clk);
        send_pause = 1'b1;
        while (in_valid || expected_levels.size() != 0) @(negedge clk);
        repeat (5) @(negedge clk);
        send_pause = 1'b0;
      end
      drain_block();
    end

    // Catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("led_breathe_fade_envelope_top: match");
    else
      $display("led_breathe_fade_envelope_top: mismatch");
    $finish;
  end

endmodule
